### src/ipfp_pkg.sv
// Package for the IPMB frame parser: beat and result types, status codes
// and frame-size constants. Has no dependencies; every other file imports it.
package ipfp_pkg;

    // Smallest legal request frame in bytes (header plus command plus checksum).
    localparam logic [7:0] MIN_FRAME   = 8'd6;
    // Largest number of data bytes the block passes on per frame.
    localparam int         MAX_DATA    = 32;
    localparam logic [8:0] MAX_DATA_W  = 9'(MAX_DATA);
    localparam logic [7:0] POS_MAX     = 8'hFF;
    localparam logic [7:0] BCAST_BYTE  = 8'h00;
    localparam logic [7:0] RESET_LOCAL = 8'h20;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_HDR_BAD   = 3'd2,
        STATUS_BODY_BAD  = 3'd3,
        STATUS_TOO_LONG  = 3'd4
    } status_t;

    // One input beat.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } beat_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        status_t    status;
        logic       broadcast;
        logic [5:0] net_fn;
        logic [1:0] rs_lun;
        logic [7:0] rq_sa;
        logic [5:0] rq_seq;
        logic [1:0] rq_lun;
        logic [7:0] cmd;
        logic [5:0] payload_len;
    } result_t;

endpackage

### src/ipfp_in_stage.sv
// Input register of the IPMB frame parser: captures one beat from the
// input channel. Depends on ipfp_pkg.
module ipfp_in_stage
    import ipfp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  beat_t s_beat,
    input  logic  advance,
    output logic  beat_valid,
    output beat_t beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    // The register takes a new beat when it is empty or is being drained.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

### src/ipfp_parse.sv
// Frame state and per-byte decode of the IPMB frame parser: field capture,
// checksums, data delay and the end-of-frame summary. Depends on ipfp_pkg.
module ipfp_parse
    import ipfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       advance,
    input  beat_t      beat,
    output logic       has_result,
    output result_t    result
);

    logic [7:0] local_address_reg;
    logic       at_start_reg,  at_start_next;
    logic       is_bcast_reg,  is_bcast_next;
    logic [7:0] pos_reg,       pos_next;
    logic [7:0] netfn_reg,     netfn_next;
    logic [7:0] rq_sa_reg,     rq_sa_next;
    logic [7:0] seq_reg,       seq_next;
    logic [7:0] cmd_reg,       cmd_next;
    logic [7:0] hsum_reg,      hsum_next;
    logic [7:0] bsum_reg,      bsum_next;
    logic [7:0] held_reg,      held_next;

    logic       bcast_drop;
    logic       emit;
    logic [8:0] data_idx;
    logic [8:0] frame_len;
    logic [8:0] data_count;
    logic [8:0] count_sat;
    logic [7:0] hdr_check;

    // Own address register, written directly from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_address_reg <= RESET_LOCAL;
        end else if (cfg_wr_en) begin
            local_address_reg <= cfg_wr_data;
        end
    end

    // Length and data-window arithmetic from the current byte position.
    assign data_idx   = {1'b0, pos_reg} - {1'b0, MIN_FRAME};
    assign frame_len  = {1'b0, pos_reg} + 9'd1;
    assign data_count = frame_len - {1'b0, MIN_FRAME};
    assign count_sat  = (data_count > MAX_DATA_W) ? MAX_DATA_W : data_count;
    assign bcast_drop = at_start_reg && (beat.rx_byte == BCAST_BYTE);
    assign emit       = (pos_reg >= MIN_FRAME) && (data_idx < MAX_DATA_W);

    // Next state and result for the beat in the input register.
    always_comb begin
        at_start_next = 1'b0;
        is_bcast_next = is_bcast_reg;
        pos_next      = pos_reg;
        netfn_next    = netfn_reg;
        rq_sa_next    = rq_sa_reg;
        seq_next      = seq_reg;
        cmd_next      = cmd_reg;
        hsum_next     = hsum_reg;
        bsum_next     = bsum_reg;
        held_next     = held_reg;
        hdr_check     = hsum_reg + local_address_reg;
        result        = '0;
        has_result    = 1'b0;

        if (bcast_drop) begin
            // A leading zero byte marks the frame as broadcast, and ends it as short if last.
            is_bcast_next = 1'b1;
            if (beat.frame_end) begin
                has_result       = 1'b1;
                result.last      = 1'b1;
                result.status    = STATUS_SHORT;
                result.broadcast = 1'b1;
            end
        end else begin
            if (pos_reg < 8'd2) begin
                hsum_next = hsum_reg + beat.rx_byte;
            end else begin
                bsum_next = bsum_reg + beat.rx_byte;
            end
            case (pos_reg)
                8'd0:    netfn_next = beat.rx_byte;
                8'd2:    rq_sa_next = beat.rx_byte;
                8'd3:    seq_next   = beat.rx_byte;
                8'd4:    cmd_next   = beat.rx_byte;
                default: ;
            endcase
            held_next = beat.rx_byte;
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 8'd1;
            end
            // The previous byte goes out one beat late, inside the data window.
            result.data_byte  = emit ? held_reg : 8'd0;
            result.byte_valid = emit;
            has_result        = emit || beat.frame_end;

            // Summary on the final byte.
            hdr_check = hsum_next + local_address_reg;
            if (beat.frame_end) begin
                result.last      = 1'b1;
                result.broadcast = is_bcast_reg;
                if (frame_len < {1'b0, MIN_FRAME}) begin
                    result.status = STATUS_SHORT;
                end else begin
                    if (hdr_check != 8'd0) begin
                        result.status = STATUS_HDR_BAD;
                    end else if (bsum_next != 8'd0) begin
                        result.status = STATUS_BODY_BAD;
                    end else if (data_count > MAX_DATA_W) begin
                        result.status = STATUS_TOO_LONG;
                    end else begin
                        result.status = STATUS_OK;
                    end
                    result.net_fn      = netfn_next[7:2];
                    result.rs_lun      = netfn_next[1:0];
                    result.rq_sa       = rq_sa_next;
                    result.rq_seq      = seq_next[7:2];
                    result.rq_lun      = seq_next[1:0];
                    result.cmd         = cmd_next;
                    result.payload_len = count_sat[5:0];
                end
            end
        end

        // Every frame end returns the frame state to its reset values.
        if (beat.frame_end) begin
            at_start_next = 1'b1;
            is_bcast_next = 1'b0;
            pos_next      = 8'd0;
            netfn_next    = 8'd0;
            rq_sa_next    = 8'd0;
            seq_next      = 8'd0;
            cmd_next      = 8'd0;
            hsum_next     = 8'd0;
            bsum_next     = 8'd0;
            held_next     = 8'd0;
        end
    end

    // Frame state registers, updated once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
            is_bcast_reg <= 1'b0;
            pos_reg      <= 8'd0;
            netfn_reg    <= 8'd0;
            rq_sa_reg    <= 8'd0;
            seq_reg      <= 8'd0;
            cmd_reg      <= 8'd0;
            hsum_reg     <= 8'd0;
            bsum_reg     <= 8'd0;
            held_reg     <= 8'd0;
        end else if (advance) begin
            at_start_reg <= at_start_next;
            is_bcast_reg <= is_bcast_next;
            pos_reg      <= pos_next;
            netfn_reg    <= netfn_next;
            rq_sa_reg    <= rq_sa_next;
            seq_reg      <= seq_next;
            cmd_reg      <= cmd_next;
            hsum_reg     <= hsum_next;
            bsum_reg     <= bsum_next;
            held_reg     <= held_next;
        end
    end

endmodule

### src/ipfp_out_stage.sv
// Output register of the IPMB frame parser: holds one result beat until the
// downstream side takes it. Depends on ipfp_pkg.
module ipfp_out_stage
    import ipfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    out_free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The register can take a new result when empty or being read this cycle.
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

### src/ipmb_frame_parser.sv
// Top level of the IPMB request frame parser: input register, frame decode
// and output register. Depends on ipfp_pkg, ipfp_in_stage, ipfp_parse, ipfp_out_stage.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    rx_byte, frame_end
//   m_        out        m_valid/m_ready    data_byte ... payload_len (summary on last)
//   cfg_      in         cfg_wr_en          cfg_wr_data = local_address
//
// One byte per cycle is taken while the output is not stalled; the result a
// byte causes is decoded from the input register and loaded into the output
// register once that has room. A data byte itself rides on the result of
// the byte that follows it. Reset (aresetn low, synchronous) empties both
// registers, clears the frame state and sets local_address to 0x20. A stalled
// output holds its result and the input register fills, after which s_ready
// drops until m_ready returns.
module ipmb_frame_parser
    import ipfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic       m_last,
    output logic [2:0] m_status,
    output logic       m_broadcast,
    output logic [5:0] m_net_fn,
    output logic [1:0] m_rs_lun,
    output logic [7:0] m_rq_sa,
    output logic [5:0] m_rq_seq,
    output logic [1:0] m_rq_lun,
    output logic [7:0] m_cmd,
    output logic [5:0] m_payload_len
);

    beat_t   s_beat;
    beat_t   beat;
    logic    beat_valid;
    logic    advance;
    logic    out_free;
    logic    has_result;
    result_t result;
    result_t m_result;

    assign s_beat.rx_byte   = s_rx_byte;
    assign s_beat.frame_end = s_frame_end;

    // A beat is decoded when the output register has room for its result.
    assign advance = beat_valid && out_free;

    ipfp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ipfp_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .beat        (beat),
        .has_result  (has_result),
        .result      (result)
    );

    ipfp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && has_result),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Result fields onto their ports.
    assign m_data_byte   = m_result.data_byte;
    assign m_byte_valid  = m_result.byte_valid;
    assign m_last        = m_result.last;
    assign m_status      = m_result.status;
    assign m_broadcast   = m_result.broadcast;
    assign m_net_fn      = m_result.net_fn;
    assign m_rs_lun      = m_result.rs_lun;
    assign m_rq_sa       = m_result.rq_sa;
    assign m_rq_seq      = m_result.rq_seq;
    assign m_rq_lun      = m_result.rq_lun;
    assign m_cmd         = m_result.cmd;
    assign m_payload_len = m_result.payload_len;

endmodule

### tb/sv/ipmb_frame_parser_tb.sv
// Testbench for the IPMB frame parser: sends request frames byte by byte and
// checks every output beat against a cycle-free prediction of the parser.
// Depends on ipfp_pkg and ipmb_frame_parser.
`timescale 1ns / 100ps

module ipmb_frame_parser_tb;
    import ipfp_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         PHASE_BYTES    = 240;
    localparam int         NUM_PHASES     = 6;
    localparam int         REPORT_LIMIT   = 10;
    localparam logic [1:0] BAD_HDR        = 2'b01;
    localparam logic [1:0] BAD_BODY       = 2'b10;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte   = 8'h00;
    logic       s_frame_end = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_data_byte;
    logic       m_byte_valid;
    logic       m_last;
    logic [2:0] m_status;
    logic       m_broadcast;
    logic [5:0] m_net_fn;
    logic [1:0] m_rs_lun;
    logic [7:0] m_rq_sa;
    logic [5:0] m_rq_seq;
    logic [1:0] m_rq_lun;
    logic [7:0] m_cmd;
    logic [5:0] m_payload_len;

    // Frame bytes waiting for the driver, and output beats still to arrive.
    beat_t   tx_bytes[$];
    result_t due_outputs[$];
    int      bytes_queued   = 0;
    int      bytes_accepted = 0;
    int      mismatches     = 0;
    int      cycle_no       = 0;
    int      quiet_cycles   = 0;

    // Shadow copy of the parser's register and frame state.
    logic [7:0] local_addr = RESET_LOCAL;
    logic       at_start   = 1'b1;
    logic       in_bcast   = 1'b0;
    logic [7:0] pos        = 8'h00;
    logic [7:0] netfn_q    = 8'h00;
    logic [7:0] rqsa_q     = 8'h00;
    logic [7:0] seqlun_q   = 8'h00;
    logic [7:0] cmd_q      = 8'h00;
    logic [7:0] hdr_sum    = 8'h00;
    logic [7:0] body_sum   = 8'h00;
    logic [7:0] held_q     = 8'h00;

    ipmb_frame_parser u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_last        (m_last),
        .m_status      (m_status),
        .m_broadcast   (m_broadcast),
        .m_net_fn      (m_net_fn),
        .m_rs_lun      (m_rs_lun),
        .m_rq_sa       (m_rq_sa),
        .m_rq_seq      (m_rq_seq),
        .m_rq_lun      (m_rq_lun),
        .m_cmd         (m_cmd),
        .m_payload_len (m_payload_len)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random idle cycles, about 16 in a hundred, except in a recurring quiet
    // stretch where both sides run flat out.
    function automatic logic skip_cycle();
        if ((cycle_no % 2500) >= 1700) begin
            return 1'b0;
        end
        return $urandom_range(99) < 16;
    endfunction

    task automatic restart_frame();
        at_start = 1'b1;
        in_bcast = 1'b0;
        pos      = 8'h00;
        netfn_q  = 8'h00;
        rqsa_q   = 8'h00;
        seqlun_q = 8'h00;
        cmd_q    = 8'h00;
        hdr_sum  = 8'h00;
        body_sum = 8'h00;
        held_q   = 8'h00;
    endtask

    // Predicts the output beat, if any, that one accepted frame byte causes.
    task automatic parse_frame_byte(input logic [7:0] b, input logic fe);
        result_t r;
        int      p;
        int      len;
        int      count;
        logic    emit;
        r    = '0;
        p    = int'(pos);
        emit = 1'b0;
        // A zero at the start of a frame flags a broadcast, and ends it as short if last.
        if (at_start && b == BCAST_BYTE) begin
            at_start = 1'b0;
            in_bcast = 1'b1;
            if (fe) begin
                r.last      = 1'b1;
                r.status    = STATUS_SHORT;
                r.broadcast = 1'b1;
                due_outputs.push_back(r);
                restart_frame();
            end
            return;
        end
        at_start = 1'b0;
        if (p < 2) begin
            hdr_sum = hdr_sum + b;
        end else begin
            body_sum = body_sum + b;
        end
        case (p)
            0: netfn_q = b;
            2: rqsa_q = b;
            3: seqlun_q = b;
            4: cmd_q = b;
            default: ;
        endcase
        // Data bytes leave one byte late, and only the first MAX_DATA of them.
        if (p >= int'(MIN_FRAME) && (p - int'(MIN_FRAME)) < MAX_DATA) begin
            emit         = 1'b1;
            r.data_byte  = held_q;
            r.byte_valid = 1'b1;
        end
        held_q = b;
        if (pos != POS_MAX) begin
            pos = pos + 8'd1;
        end
        if (fe) begin
            len         = p + 1;
            r.last      = 1'b1;
            r.broadcast = in_bcast;
            if (len < int'(MIN_FRAME)) begin
                r.status = STATUS_SHORT;
            end else begin
                count = len - int'(MIN_FRAME);
                if (8'(hdr_sum + local_addr) != 8'h00) begin
                    r.status = STATUS_HDR_BAD;
                end else if (body_sum != 8'h00) begin
                    r.status = STATUS_BODY_BAD;
                end else if (count > MAX_DATA) begin
                    r.status = STATUS_TOO_LONG;
                end else begin
                    r.status = STATUS_OK;
                end
                if (count > MAX_DATA) begin
                    count = MAX_DATA;
                end
                r.net_fn      = netfn_q[7:2];
                r.rs_lun      = netfn_q[1:0];
                r.rq_sa       = rqsa_q;
                r.rq_seq      = seqlun_q[7:2];
                r.rq_lun      = seqlun_q[1:0];
                r.cmd         = cmd_q;
                r.payload_len = 6'(count);
            end
        end
        if (emit || fe) begin
            due_outputs.push_back(r);
        end
        if (fe) begin
            restart_frame();
        end
    endtask

    function automatic string field_diffs(result_t want, result_t got);
        string s = "";
        if (want.data_byte !== got.data_byte)
            s = {s, $sformatf(" data_byte %h/%h", want.data_byte, got.data_byte)};
        if (want.byte_valid !== got.byte_valid)
            s = {s, $sformatf(" byte_valid %b/%b", want.byte_valid, got.byte_valid)};
        if (want.last !== got.last)
            s = {s, $sformatf(" last %b/%b", want.last, got.last)};
        if (want.status !== got.status)
            s = {s, $sformatf(" status %0d/%0d", want.status, got.status)};
        if (want.broadcast !== got.broadcast)
            s = {s, $sformatf(" broadcast %b/%b", want.broadcast, got.broadcast)};
        if (want.net_fn !== got.net_fn)
            s = {s, $sformatf(" net_fn %h/%h", want.net_fn, got.net_fn)};
        if (want.rs_lun !== got.rs_lun)
            s = {s, $sformatf(" rs_lun %h/%h", want.rs_lun, got.rs_lun)};
        if (want.rq_sa !== got.rq_sa)
            s = {s, $sformatf(" rq_sa %h/%h", want.rq_sa, got.rq_sa)};
        if (want.rq_seq !== got.rq_seq)
            s = {s, $sformatf(" rq_seq %h/%h", want.rq_seq, got.rq_seq)};
        if (want.rq_lun !== got.rq_lun)
            s = {s, $sformatf(" rq_lun %h/%h", want.rq_lun, got.rq_lun)};
        if (want.cmd !== got.cmd)
            s = {s, $sformatf(" cmd %h/%h", want.cmd, got.cmd)};
        if (want.payload_len !== got.payload_len)
            s = {s, $sformatf(" payload_len %0d/%0d", want.payload_len, got.payload_len)};
        return s;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic fe);
        beat_t bt;
        bt.rx_byte   = b;
        bt.frame_end = fe;
        tx_bytes.push_back(bt);
        bytes_queued++;
    endtask

    // Builds one request frame with correct sums unless a fault is asked for,
    // and optionally cuts it short after a number of bytes.
    task automatic queue_frame(input bit bcast, input logic [7:0] nf, sa, sl, cm,
                               input int n_data, input logic [1:0] faults,
                               input int keep);
        logic [7:0] bytes[$];
        logic [7:0] body;
        logic [7:0] b;
        int         i;
        if (bcast) begin
            bytes.push_back(BCAST_BYTE);
        end
        bytes.push_back(nf);
        b = 8'h00 - local_addr - nf;
        if ((faults & BAD_HDR) != 2'b00) begin
            b = b + 8'($urandom_range(1, 255));
        end
        bytes.push_back(b);
        bytes.push_back(sa);
        bytes.push_back(sl);
        bytes.push_back(cm);
        body = sa + sl + cm;
        for (i = 0; i < n_data; i++) begin
            b    = 8'($urandom);
            body = body + b;
            bytes.push_back(b);
        end
        b = 8'h00 - body;
        if ((faults & BAD_BODY) != 2'b00) begin
            b = b + 8'($urandom_range(1, 255));
        end
        bytes.push_back(b);
        while (keep > 0 && bytes.size() > keep) begin
            void'(bytes.pop_back());
        end
        for (i = 0; i < bytes.size(); i++) begin
            queue_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // Mostly well-formed frames with random content, plus faulty sums,
    // truncated frames, oversized frames and plain noise.
    task automatic queue_random_frame();
        int         roll;
        int         n;
        int         i;
        int         keep;
        bit         bcast;
        logic [1:0] faults;
        logic [7:0] nf;
        roll = $urandom_range(99);
        if (roll < 10) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
                queue_byte(8'($urandom), i == n - 1);
            end
            return;
        end
        bcast = ($urandom_range(3) == 0);
        roll  = $urandom_range(99);
        if (roll < 60) begin
            n = $urandom_range(0, 12);
        end else if (roll < 88) begin
            n = $urandom_range(13, MAX_DATA);
        end else begin
            n = $urandom_range(MAX_DATA + 1, MAX_DATA + 12);
        end
        faults = 2'b00;
        if ($urandom_range(99) < 10) faults = faults | BAD_HDR;
        if ($urandom_range(99) < 10) faults = faults | BAD_BODY;
        keep = ($urandom_range(99) < 8) ? $urandom_range(1, 6) : 0;
        // Without a broadcast prefix a zero first byte would read as one.
        nf = bcast ? 8'($urandom) : 8'($urandom_range(1, 255));
        queue_frame(bcast, nf, 8'($urandom), 8'($urandom), 8'($urandom), n, faults, keep);
    endtask

    // Waits until every queued byte is taken and every predicted beat is seen,
    // then lets the pipeline settle.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (bytes_accepted != bytes_queued || due_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_local_addr(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        local_addr = v;
    endtask

    // Input driver: presents queued bytes and updates the prediction for
    // every beat that is accepted.
    always @(posedge aclk) begin
        beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_frame_byte(s_rx_byte, s_frame_end);
                bytes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_bytes.size() != 0 && !skip_cycle()) begin
                    nxt = tx_bytes.pop_front();
                    s_valid     <= 1'b1;
                    s_rx_byte   <= nxt.rx_byte;
                    s_frame_end <= nxt.frame_end;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random back-pressure and a check of each accepted beat.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        string   diffs;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !skip_cycle();
            if (m_valid && m_ready) begin
                got.data_byte   = m_data_byte;
                got.byte_valid  = m_byte_valid;
                got.last        = m_last;
                got.status      = status_t'(m_status);
                got.broadcast   = m_broadcast;
                got.net_fn      = m_net_fn;
                got.rs_lun      = m_rs_lun;
                got.rq_sa       = m_rq_sa;
                got.rq_seq      = m_rq_seq;
                got.rq_lun      = m_rq_lun;
                got.cmd         = m_cmd;
                got.payload_len = m_payload_len;
                if (due_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] unexpected output beat %h", $realtime, got);
                end else begin
                    want  = due_outputs.pop_front();
                    diffs = field_diffs(want, got);
                    if (diffs != "") begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("[%0t] mismatch (expected/actual):%s", $realtime, diffs);
                    end
                end
            end
        end
    end

    // Cycle count and watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        cycle_no++;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat accepted for %0d cycles", $realtime,
                     WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus: reset, a directed set of frames, then random phases under
    // several local addresses.
    initial begin
        int         ph;
        int         start;
        logic [7:0] addr;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Lone broadcast zero that also ends the frame.
        queue_byte(BCAST_BYTE, 1'b1);
        // Broadcast frame with zero netFn byte and one data byte.
        queue_frame(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00, 1, 2'b00, 0);
        // Frame cut off after two bytes.
        queue_frame(1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 0, 2'b00, 2);
        // Minimal frames with a bad header sum and with a bad body sum.
        queue_frame(1'b0, 8'hFC, 8'h00, 8'h03, 8'hFF, 0, BAD_HDR, 0);
        queue_frame(1'b0, 8'h01, 8'h81, 8'hFE, 8'h7F, 0, BAD_BODY, 0);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                if (ph == 1) addr = 8'h00;
                else if (ph == 2) addr = 8'hFF;
                else addr = 8'($urandom);
                write_local_addr(addr);
            end
            start = bytes_queued;
            // A full-size frame and one just over the data limit each phase.
            queue_frame(1'b0, 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                        8'($urandom), MAX_DATA, 2'b00, 0);
            queue_frame(1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), MAX_DATA + 1, 2'b00, 0);
            // One frame long enough to saturate the byte position.
            if (ph == 2)
                queue_frame(1'b0, 8'h55, 8'hAA, 8'h33, 8'hCC, 256, 2'b00, 0);
            while (bytes_queued - start < PHASE_BYTES) begin
                queue_random_frame();
            end
        end
        wait_drained();

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
